[src/dtae_pkg.sv]
// Shared types, constants and twiddle generation for the time alignment estimator.
`timescale 1ns / 1ps
package dtae_pkg;

	localparam int unsigned MAX_AW = 12;
	localparam int unsigned IDX_W = MAX_AW + 1;
	localparam int unsigned WIN_W = 11;
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	typedef enum logic [3:0] {
		ST_RST_CLR,
		ST_IDLE,
		ST_LOAD,
		ST_BIN_INIT,
		ST_ISSUE,
		ST_DRAIN,
		ST_SCALE,
		ST_SQUARE,
		ST_POWER,
		ST_CMP,
		ST_FIN,
		ST_CLR_ISSUE,
		ST_CLR_DRAIN
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic load_wr;
		logic rst_clr;
		logic list_rd;
		logic clr_mode;
		logic search_start;
		logic bin_init;
		logic phase;
		logic scale;
		logic square;
		logic power;
		logic cmp;
		logic first;
		logic fin;
		logic frame_done;
		logic [IDX_W-1:0] idx;
		logic [WIN_W-1:0] bin;
	} ctl_cmd_t;

	typedef struct packed {
		logic pipe_empty;
		logic out_busy;
		logic last;
		logic [IDX_W-1:0] used_cnt;
		logic [WIN_W-1:0] win;
	} ctl_sts_t;

	function automatic logic signed [31:0] q30_to_tw(input longint acc_in, input int unsigned frac);
		longint acc;
		longint v;
		longint top;
		acc = acc_in;
		top = (64'sd1 <<< frac) - 64'sd1;
		if (acc < 0) acc = 0;
		v = (acc + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
		if (v > top) v = top;
		return 32'(v);
	endfunction

	// restoring long division, used only while building the twiddle table
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// {sin, cos} of 2*pi*m/2^aw, each a 32-bit signed value in Q(frac)
	function automatic logic [63:0] tw_entry(input int unsigned aw, input int unsigned m,
			input int unsigned frac);
		longint unsigned q;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned tc;
		longint unsigned ts;
		longint unsigned dc;
		longint unsigned ds;
		longint ac;
		longint as_v;
		logic signed [31:0] c;
		logic signed [31:0] s;
		logic signed [31:0] oc;
		logic signed [31:0] os;
		q = (64'(m) * 64'd4) >> aw;
		r = (64'(m) * 64'd4) & ((64'd1 << aw) - 64'd1);
		x = (PI_HALF_Q30 * r) >> aw;
		x2 = (x * x) >> 30;
		tc = 64'd1 << 30;
		ts = x;
		ac = longint'(tc);
		as_v = longint'(ts);
		for (int k = 0; k < 12; k++) begin
			dc = 64'((2 * k + 1) * (2 * k + 2));
			ds = 64'((2 * k + 2) * (2 * k + 3));
			tc = udiv64((tc * x2) >> 30, dc);
			ts = udiv64((ts * x2) >> 30, ds);
			if ((k & 1) == 1) begin
				ac = ac + longint'(tc);
				as_v = as_v + longint'(ts);
			end else begin
				ac = ac - longint'(tc);
				as_v = as_v - longint'(ts);
			end
		end
		c = q30_to_tw(ac, frac);
		s = q30_to_tw(as_v, frac);
		unique case (q[1:0])
			2'd0: begin oc = c;  os = s;  end
			2'd1: begin oc = -s; os = c;  end
			2'd2: begin oc = -c; os = -s; end
			default: begin oc = s; os = -c; end
		endcase
		return {os, oc};
	endfunction

endpackage

[src/dtae_ctrl.sv]
// Controller state machine: pilot load, per-bin transform sequencing, search and frame clear.
`timescale 1ns / 1ps
module dtae_ctrl #(
	parameter int IDFT_LEN = 2048
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_valid,
	output logic s_ready,
	output dtae_pkg::ctl_cmd_t cmd,
	input  dtae_pkg::ctl_sts_t sts
);
	localparam int unsigned IW = dtae_pkg::IDX_W;
	localparam int unsigned WW = dtae_pkg::WIN_W;

	dtae_pkg::ctl_state_t state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [WW-1:0] bin_q, bin_d;
	logic phase_q, phase_d;
	logic [IW-1:0] cnt_m1;

	assign cnt_m1 = sts.used_cnt - IW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtae_pkg::ST_RST_CLR;
			idx_q <= '0;
			bin_q <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			bin_q <= bin_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		bin_d = bin_q;
		phase_d = phase_q;
		s_ready = 1'b0;
		cmd = '0;
		cmd.idx = idx_q;
		cmd.bin = bin_q;
		cmd.phase = phase_q;
		cmd.first = (bin_q == '0);
		unique case (state_q)
			dtae_pkg::ST_RST_CLR: begin
				cmd.rst_clr = 1'b1;
				idx_d = idx_q + IW'(1);
				if (idx_q == IW'(IDFT_LEN - 1)) begin
					idx_d = '0;
					state_d = dtae_pkg::ST_IDLE;
				end
			end
			dtae_pkg::ST_IDLE: begin
				s_ready = 1'b1;
				cmd.accept = s_valid;
				if (s_valid) state_d = dtae_pkg::ST_LOAD;
			end
			dtae_pkg::ST_LOAD: begin
				cmd.load_wr = 1'b1;
				if (sts.last) begin
					cmd.search_start = 1'b1;
					bin_d = '0;
					phase_d = 1'b0;
					state_d = dtae_pkg::ST_BIN_INIT;
				end else begin
					state_d = dtae_pkg::ST_IDLE;
				end
			end
			dtae_pkg::ST_BIN_INIT: begin
				cmd.bin_init = 1'b1;
				idx_d = '0;
				state_d = (sts.used_cnt == '0) ? dtae_pkg::ST_DRAIN : dtae_pkg::ST_ISSUE;
			end
			dtae_pkg::ST_ISSUE: begin
				cmd.list_rd = 1'b1;
				idx_d = idx_q + IW'(1);
				if (idx_q == cnt_m1) state_d = dtae_pkg::ST_DRAIN;
			end
			dtae_pkg::ST_DRAIN: begin
				if (sts.pipe_empty) state_d = dtae_pkg::ST_SCALE;
			end
			dtae_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = dtae_pkg::ST_SQUARE;
			end
			dtae_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d = dtae_pkg::ST_POWER;
			end
			dtae_pkg::ST_POWER: begin
				cmd.power = 1'b1;
				state_d = dtae_pkg::ST_CMP;
			end
			dtae_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = dtae_pkg::ST_BIN_INIT;
				if (bin_q == sts.win - WW'(1)) begin
					bin_d = '0;
					if (phase_q) state_d = dtae_pkg::ST_FIN;
					else phase_d = 1'b1;
				end else begin
					bin_d = bin_q + WW'(1);
				end
			end
			dtae_pkg::ST_FIN: begin
				idx_d = '0;
				if (!sts.out_busy) begin
					cmd.fin = 1'b1;
					if (sts.used_cnt == '0) begin
						cmd.frame_done = 1'b1;
						state_d = dtae_pkg::ST_IDLE;
					end else begin
						state_d = dtae_pkg::ST_CLR_ISSUE;
					end
				end
			end
			dtae_pkg::ST_CLR_ISSUE: begin
				cmd.list_rd = 1'b1;
				cmd.clr_mode = 1'b1;
				idx_d = idx_q + IW'(1);
				if (idx_q == cnt_m1) state_d = dtae_pkg::ST_CLR_DRAIN;
			end
			dtae_pkg::ST_CLR_DRAIN: begin
				if (sts.pipe_empty) begin
					cmd.frame_done = 1'b1;
					state_d = dtae_pkg::ST_IDLE;
				end
			end
			default: state_d = dtae_pkg::ST_IDLE;
		endcase
	end

endmodule

[src/dtae_dpath.sv]
// Datapath: pilot and slot-list memories, twiddle ROM, MAC pipeline, power and peak search.
`timescale 1ns / 1ps
module dtae_dpath #(
	parameter int IDFT_LEN = 2048,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [47:0] s_tdata,
	input  logic s_tlast,
	input  logic cfg_we,
	input  logic [10:0] cfg_wdata,
	output logic m_valid,
	input  logic m_ready,
	output logic [23:0] m_tdata,
	output logic m_tuser,
	input  dtae_pkg::ctl_cmd_t cmd,
	output dtae_pkg::ctl_sts_t sts
);
	localparam int N = IDFT_LEN;
	localparam int AW = $clog2(IDFT_LEN);
	localparam int SW = SAMPLE_WIDTH;
	localparam int PW = 16 + SW;
	localparam int ACC_W = PW + AW + 2;
	localparam int SH = SW - 1;
	localparam int ABS_W = ACC_W - SH;
	localparam int SQ_W = 2 * ABS_W;
	localparam int PWR_W = SQ_W + 1;
	localparam int IW = dtae_pkg::IDX_W;
	localparam int WW = dtae_pkg::WIN_W;
	localparam int DEF_W = 72 * IDFT_LEN / 2048;
	localparam int CAP_W = (IDFT_LEN < 1024) ? IDFT_LEN : 1024;

	logic [32:0] freq_mem [N];
	logic [AW-1:0] list_mem [N];
	logic signed [SW-1:0] rom_cos [N];
	logic signed [SW-1:0] rom_sin [N];

	for (genvar g = 0; g < N; g++) begin : g_rom
		localparam logic [63:0] E = dtae_pkg::tw_entry(AW, g, SH);
		assign rom_cos[g] = E[SW-1:0];
		assign rom_sin[g] = E[32+SW-1:32];
	end

	logic [10:0] cfg_q;
	logic [15:0] re_q, im_q;
	logic [AW-1:0] slot_q;
	logic slot_ok_q, last_q;
	logic [IW-1:0] cnt_q;
	logic [WW-1:0] win_q;
	logic [AW-1:0] n_q;
	logic [32:0] freq_rd_q;
	logic [AW-1:0] list_q;

	logic v1_s1, clr_s1, v2_s2, v3_s3, v4_s4;
	logic [AW-1:0] m_s2;
	logic signed [SW-1:0] cos_s3, sin_s3;
	logic signed [15:0] xr_s3, xi_s3;
	logic signed [PW-1:0] prc_s4, pis_s4, prs_s4, pic_s4;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic [ABS_W-1:0] abs_re_q, abs_im_q;
	logic [SQ_W-1:0] sq_re_q, sq_im_q;
	logic [PWR_W-1:0] pwr_q, best_d_q, best_a_q;
	logic [WW-1:0] didx_q, aidx_q;
	logic m_valid_q;
	logic [WW-1:0] ta_q, wu_q;
	logic adv_q;

	logic [12:0] slot_in;
	logic slot_in_ok;
	logic [AW-1:0] rd_addr;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [32:0] mem_wd;
	logic [2*AW-1:0] kn;
	logic [WW-1:0] wsel;
	logic [AW:0] n_adv;
	logic signed [ABS_W-1:0] sc_re, sc_im;

	assign slot_in = 13'(s_tdata[42:32]);
	assign slot_in_ok = (slot_in < 13'(N));
	assign rd_addr = cmd.accept ? slot_in[AW-1:0] : list_q;
	assign kn = list_q * n_q;
	assign wsel = (cfg_q == '0) ? WW'(DEF_W) : cfg_q;
	assign n_adv = (AW+1)'(N) - (AW+1)'(win_q) + (AW+1)'(cmd.bin);
	assign sc_re = ABS_W'(acc_re_q >>> SH);
	assign sc_im = ABS_W'(acc_im_q >>> SH);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = '0;
		priority if (cmd.rst_clr) begin
			mem_we = 1'b1;
			mem_wa = cmd.idx[AW-1:0];
		end else if (v1_s1 && clr_s1) begin
			mem_we = 1'b1;
			mem_wa = list_q;
		end else if (cmd.load_wr && slot_ok_q) begin
			mem_we = 1'b1;
			mem_wd = {1'b1, im_q, re_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) freq_mem[mem_wa] <= mem_wd;
		freq_rd_q <= freq_mem[rd_addr];
		if (cmd.load_wr && slot_ok_q && !freq_rd_q[32]) list_mem[cnt_q[AW-1:0]] <= slot_q;
		list_q <= list_mem[cmd.idx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
			cnt_q <= '0;
			last_q <= 1'b0;
			slot_ok_q <= 1'b0;
			v1_s1 <= 1'b0;
			clr_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			m_valid_q <= 1'b0;
			win_q <= WW'(DEF_W);
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			if (cmd.accept) begin
				last_q <= s_tlast;
				slot_ok_q <= slot_in_ok;
			end
			if (cmd.frame_done) cnt_q <= '0;
			else if (cmd.load_wr && slot_ok_q && !freq_rd_q[32]) cnt_q <= cnt_q + IW'(1);
			if (cmd.search_start) win_q <= (wsel > WW'(CAP_W)) ? WW'(CAP_W) : wsel;
			v1_s1 <= cmd.list_rd;
			clr_s1 <= cmd.clr_mode;
			v2_s2 <= v1_s1 && !clr_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			if (cmd.fin) m_valid_q <= 1'b1;
			else if (m_ready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			re_q <= s_tdata[15:0];
			im_q <= s_tdata[31:16];
			slot_q <= slot_in[AW-1:0];
		end
		if (cmd.bin_init) n_q <= cmd.phase ? n_adv[AW-1:0] : AW'(cmd.bin);
		m_s2 <= kn[AW-1:0];
		cos_s3 <= rom_cos[m_s2];
		sin_s3 <= rom_sin[m_s2];
		xr_s3 <= freq_rd_q[15:0];
		xi_s3 <= freq_rd_q[31:16];
		prc_s4 <= xr_s3 * cos_s3;
		pis_s4 <= xi_s3 * sin_s3;
		prs_s4 <= xr_s3 * sin_s3;
		pic_s4 <= xi_s3 * cos_s3;
		if (cmd.bin_init) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v4_s4) begin
			acc_re_q <= acc_re_q + ACC_W'(prc_s4) - ACC_W'(pis_s4);
			acc_im_q <= acc_im_q + ACC_W'(prs_s4) + ACC_W'(pic_s4);
		end
		if (cmd.scale) begin
			abs_re_q <= sc_re[ABS_W-1] ? ABS_W'(-sc_re) : ABS_W'(sc_re);
			abs_im_q <= sc_im[ABS_W-1] ? ABS_W'(-sc_im) : ABS_W'(sc_im);
		end
		if (cmd.square) begin
			sq_re_q <= abs_re_q * abs_re_q;
			sq_im_q <= abs_im_q * abs_im_q;
		end
		if (cmd.power) pwr_q <= PWR_W'(sq_re_q) + PWR_W'(sq_im_q);
		if (cmd.cmp) begin
			if (!cmd.phase) begin
				if (cmd.first || pwr_q > best_d_q) begin
					best_d_q <= pwr_q;
					didx_q <= cmd.bin;
				end
			end else begin
				if (cmd.first || pwr_q > best_a_q) begin
					best_a_q <= pwr_q;
					aidx_q <= cmd.bin;
				end
			end
		end
		if (cmd.fin) begin
			adv_q <= best_d_q < best_a_q;
			ta_q <= (best_d_q < best_a_q) ? (aidx_q - win_q) : didx_q;
			wu_q <= win_q;
		end
	end

	assign m_valid = m_valid_q;
	assign m_tdata = {2'b00, wu_q, ta_q};
	assign m_tuser = adv_q;

	assign sts.pipe_empty = !(v1_s1 || v2_s2 || v3_s3 || v4_s4);
	assign sts.out_busy = m_valid_q;
	assign sts.last = last_q;
	assign sts.used_cnt = cnt_q;
	assign sts.win = win_q;

endmodule

[src/dft_time_alignment_estimator_core.sv]
// Top level of the inverse DFT peak search time alignment estimator.
// Each pilot request reads the slot entry, then writes it; no new pilot is taken until the write.
// On the last pilot: 2*W bins, each a MAC pass over the U distinct slots loaded,
// then a clear pass over those U slots before the next pilot is taken.
// After reset a clearing pass over all IDFT_LEN entries runs before any pilot is taken.
// Reset is asynchronous, active low; the window register resets to zero (default W).
`timescale 1ns / 1ps
module dft_time_alignment_estimator_core #(
	parameter int IDFT_LEN = 2048,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // pilot_re[15:0], pilot_im[31:16], slot_index[42:32]
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata,   // ta_samples[10:0], window_used[21:11]
	output logic m_axis_tuser,          // from_advance
	input  logic cfg_we,
	input  logic [10:0] cfg_wdata
);
	dtae_pkg::ctl_cmd_t cmd;
	dtae_pkg::ctl_sts_t sts;

	dtae_ctrl #(
		.IDFT_LEN(IDFT_LEN)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.cmd(cmd),
		.sts(sts)
	);

	dtae_dpath #(
		.IDFT_LEN(IDFT_LEN),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_axis_tdata),
		.s_tlast(s_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.m_tuser(m_axis_tuser),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

[tb/sv/dft_time_alignment_estimator_core_test.sv]
// Testbench for the time alignment estimator: pilot frames checked against an IDFT peak predictor.
`timescale 1ns / 1ps
module dft_time_alignment_estimator_core_test;
	localparam int N = 2048;
	localparam int TW_FRAC = 15;
	localparam int WATCHDOG_LIMIT = 1000000;

	typedef struct {
		logic signed [10:0] ta;
		logic [10:0] win;
		logic adv;
	} align_t;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [10:0] slot;
		logic last;
		logic typed;
		logic signed [10:0] ta;
	} pilot_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;

	dft_time_alignment_estimator_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	int tw_c[N];
	int tw_s[N];
	longint bin_re[N];
	longint bin_im[N];
	bit bin_set[N];
	int set_slots[$];
	logic [10:0] win_reg = '0;
	align_t align_q[$];
	int errors = 0;
	int pilots = 0;
	int frames = 0;
	int results = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	int hold_left = 0;

	function automatic int round_q30(longint acc);
		longint v;
		if (acc < 0) acc = 0;
		v = (acc + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
		if (v > 32767) v = 32767;
		return int'(v);
	endfunction

	// cos/sin table in Q15 by quadrant-reduced Taylor series computed in Q30
	task automatic make_twiddles();
		longint unsigned q, r, x, x2, tc, ts;
		longint ac, sa;
		int c, s;
		for (int m = 0; m < N; m++) begin
			q = (4 * m) / N;
			r = 4 * m - q * N;
			x = (64'd1686629713 * r) / N;
			x2 = (x * x) >> 30;
			tc = 64'd1 << 30;
			ts = x;
			ac = longint'(tc);
			sa = longint'(ts);
			for (int k = 0; k < 12; k++) begin
				tc = ((tc * x2) >> 30) / ((2 * k + 1) * (2 * k + 2));
				ts = ((ts * x2) >> 30) / ((2 * k + 2) * (2 * k + 3));
				if (k % 2) begin
					ac += longint'(tc);
					sa += longint'(ts);
				end else begin
					ac -= longint'(tc);
					sa -= longint'(ts);
				end
			end
			c = round_q30(ac);
			s = round_q30(sa);
			case (q)
				0: begin tw_c[m] = c; tw_s[m] = s; end
				1: begin tw_c[m] = -s; tw_s[m] = c; end
				2: begin tw_c[m] = -c; tw_s[m] = -s; end
				default: begin tw_c[m] = s; tw_s[m] = -c; end
			endcase
		end
	endtask

	function automatic longint unsigned time_power(int n);
		longint sr, si, r, i;
		int k, m;
		sr = 0;
		si = 0;
		foreach (set_slots[j]) begin
			k = set_slots[j];
			m = (k * n) % N;
			sr += bin_re[k] * tw_c[m] - bin_im[k] * tw_s[m];
			si += bin_re[k] * tw_s[m] + bin_im[k] * tw_c[m];
		end
		r = sr >>> TW_FRAC;
		i = si >>> TW_FRAC;
		if (r < 0) r = -r;
		if (i < 0) i = -i;
		return r * r + i * i;
	endfunction

	// load one pilot; on last, search both windows and clear the frame
	function automatic bit load_pilot(pilot_row_t p, output align_t a);
		int w, d_idx, a_idx;
		longint unsigned pk_d, pk_a, pw;
		if (!bin_set[p.slot]) begin
			bin_set[p.slot] = 1;
			set_slots.push_back(p.slot);
		end
		bin_re[p.slot] = p.re;
		bin_im[p.slot] = p.im;
		if (!p.last) return 0;
		w = win_reg;
		if (w == 0) w = 72;
		if (w > 1024) w = 1024;
		pk_d = 0;
		pk_a = 0;
		d_idx = 0;
		a_idx = 0;
		for (int j = 0; j < w; j++) begin
			pw = time_power(j);
			if (j == 0 || pw > pk_d) begin pk_d = pw; d_idx = j; end
		end
		for (int j = 0; j < w; j++) begin
			pw = time_power(N - w + j);
			if (j == 0 || pw > pk_a) begin pk_a = pw; a_idx = j; end
		end
		a.adv = pk_d < pk_a;
		a.ta = a.adv ? 11'(-(w - a_idx)) : 11'(d_idx);
		a.win = 11'(w);
		foreach (set_slots[j]) begin
			bin_set[set_slots[j]] = 0;
			bin_re[set_slots[j]] = 0;
			bin_im[set_slots[j]] = 0;
		end
		set_slots.delete();
		return 1;
	endfunction

	task automatic send_pilot(pilot_row_t p);
		align_t a;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, p.slot, p.im, p.re};
		s_axis_tlast <= p.last;
		do @(posedge clk); while (!s_axis_tready);
		pilots++;
		if (load_pilot(p, a)) begin
			frames++;
			if (p.typed) begin
				a.ta = p.ta;
				a.win = 11'd72;
				a.adv = 1'b0;
			end
			align_q.push_back(a);
		end
	endtask

	task automatic drain_wait();
		s_axis_tvalid <= 1'b0;
		while (align_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_window(logic [10:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_reg = v;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_frames(int budget);
		pilot_row_t p;
		int len, stop_at;
		stop_at = pilots + budget;
		while (pilots < stop_at) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				p.re = rand_sample();
				p.im = rand_sample();
				p.slot = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 7)) : 11'($urandom);
				p.last = (i == len - 1);
				p.typed = 0;
				p.ta = 0;
				send_pilot(p);
			end
		end
	endtask

	// results
	initial begin
		align_t e;
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				results++;
				if (align_q.size() == 0) begin
					$display("%t unexpected result ta %0d", $realtime,
						$signed(m_axis_tdata[10:0]));
					errors++;
				end else begin
					e = align_q.pop_front();
					if (m_axis_tdata[10:0] !== e.ta) begin
						$display("%t ta exp %0d got %0d", $realtime, e.ta,
							$signed(m_axis_tdata[10:0]));
						errors++;
					end
					if (m_axis_tdata[21:11] !== e.win) begin
						$display("%t window exp %0d got %0d", $realtime, e.win,
							m_axis_tdata[21:11]);
						errors++;
					end
					if (m_axis_tuser !== e.adv) begin
						$display("%t advance exp %0d got %0d", $realtime, e.adv, m_axis_tuser);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 17);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%t watchdog expired", $realtime);
			$display("FAIL dft_time_alignment_estimator_core");
			$finish;
		end
	end

	pilot_row_t directed[] = '{
		'{16'sd0, 16'sd0, 11'd5, 1'b1, 1'b1, 11'sd0},         // empty spectrum
		'{16'sd1000, -16'sd1000, 11'd0, 1'b1, 1'b1, 11'sd0},  // DC only, flat power
		'{16'sh7fff, 16'sd0, 11'd1, 1'b0, 1'b0, 11'sd0},
		'{16'sh8000, 16'sh8000, 11'd2047, 1'b0, 1'b0, 11'sd0},
		'{16'sd12345, 16'sd777, 11'd1, 1'b1, 1'b0, 11'sd0},   // overwrites slot 1
		'{16'sh8000, 16'sh7fff, 11'd3, 1'b1, 1'b0, 11'sd0},
		'{16'sh7fff, 16'sh7fff, 11'd1024, 1'b0, 1'b0, 11'sd0},
		'{-16'sd2000, 16'sd300, 11'd2047, 1'b0, 1'b0, 11'sd0},
		'{16'sd5000, 16'sh8000, 11'd10, 1'b1, 1'b0, 11'sd0},
		'{16'sd0, 16'sh7fff, 11'd2046, 1'b1, 1'b0, 11'sd0},
		'{16'sh7fff, 16'sd0, 11'd0, 1'b0, 1'b0, 11'sd0},
		'{16'sd0, 16'sd0, 11'd0, 1'b1, 1'b1, 11'sd0}          // zero overwrite empties it
	};
	logic [10:0] phase_win[] = '{11'd1, 11'd1024, 11'd2047, 11'd7, 11'd200, 11'd0, 11'd33};
	int phase_items[] = '{200, 10, 8, 300, 50, 300, 370};

	initial begin
		make_twiddles();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) send_pilot(directed[i]);
		foreach (phase_win[i]) begin
			drain_wait();
			write_window(phase_win[i]);
			if (phase_win[i] == 11'd7) hold_left = 3000;
			if (i == phase_win.size() - 1) quiet = 1;
			random_frames(phase_items[i]);
		end
		drain_wait();
		$display("Covered %0d pilots in %0d frames, %0d results, windows 1..2047 and default",
			pilots, frames, results);
		if (errors == 0)
			$display("PASS dft_time_alignment_estimator_core");
		else
			$display("FAIL dft_time_alignment_estimator_core");
		$finish;
	end
endmodule

[filelist.f]
src/dtae_pkg.sv
src/dtae_ctrl.sv
src/dtae_dpath.sv
src/dft_time_alignment_estimator_core.sv
tb/sv/dft_time_alignment_estimator_core_test.sv
